// ----- design/rls2_pkg.sv -----
package rls2_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [16:0] FF_RESET   = 17'd65470;
  localparam logic [30:0] ICOV_RESET = 31'd65536000;

  localparam logic [1:0] CFG_FORGET = 2'd0;
  localparam logic [1:0] CFG_ICOV   = 2'd1;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_REINIT = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // datapath register codes
  localparam logic [4:0] REG_NONE = 5'd0;
  localparam logic [4:0] REG_P0   = 5'd1;
  localparam logic [4:0] REG_P1   = 5'd2;
  localparam logic [4:0] REG_P2   = 5'd3;
  localparam logic [4:0] REG_P3   = 5'd4;
  localparam logic [4:0] REG_TH0  = 5'd5;
  localparam logic [4:0] REG_TH1  = 5'd6;
  localparam logic [4:0] REG_PH0  = 5'd7;
  localparam logic [4:0] REG_PH1  = 5'd8;
  localparam logic [4:0] REG_EPS  = 5'd9;
  localparam logic [4:0] REG_PP0  = 5'd10;
  localparam logic [4:0] REG_PP1  = 5'd11;
  localparam logic [4:0] REG_K0   = 5'd12;
  localparam logic [4:0] REG_K1   = 5'd13;
  localparam logic [4:0] REG_T0   = 5'd14;
  localparam logic [4:0] REG_T1   = 5'd15;
  localparam logic [4:0] REG_T2   = 5'd16;
  localparam logic [4:0] REG_T3   = 5'd17;
  localparam logic [4:0] REG_R0   = 5'd18;
  localparam logic [4:0] REG_R1   = 5'd19;
  localparam logic [4:0] REG_R2   = 5'd20;
  localparam logic [4:0] REG_R3   = 5'd21;
  localparam logic [4:0] REG_DEN  = 5'd22;

  // accumulator start value
  localparam logic [2:0] ADD_ACC  = 3'd0;
  localparam logic [2:0] ADD_ZERO = 3'd1;
  localparam logic [2:0] ADD_Y    = 3'd2;
  localparam logic [2:0] ADD_LAM  = 3'd3;
  localparam logic [2:0] ADD_ONE  = 3'd4;
  localparam logic [2:0] ADD_TH0  = 3'd5;
  localparam logic [2:0] ADD_TH1  = 3'd6;

  localparam logic [2:0] UOP_NOP   = 3'd0;
  localparam logic [2:0] UOP_MUL   = 3'd1;
  localparam logic [2:0] UOP_DIV   = 3'd2;
  localparam logic [2:0] UOP_CHECK = 3'd3;
  localparam logic [2:0] UOP_END   = 3'd4;

  localparam int STEP_W = 5;

  typedef struct packed {
    logic              cmd;
    logic signed [31:0] regressor_a;
    logic signed [31:0] regressor_b;
    logic signed [31:0] measured_output;
  } in_t;

  typedef struct packed {
    logic signed [31:0] estimate_a;
    logic signed [31:0] estimate_b;
    logic signed [31:0] prediction_error;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] a_sel;
    logic [4:0] b_sel;
    logic [2:0] add_sel;
    logic       neg;
    logic [4:0] dst;
    logic       den_lam;
  } uop_t;

  typedef struct packed {
    logic       capture;
    logic       reinit;
    logic       issue;
    logic [4:0] a_sel;
    logic [4:0] b_sel;
    logic [2:0] add_sel;
    logic       neg;
    logic [4:0] dst;
    logic       div_start;
    logic       den_lam;
    logic       finish;
    logic       skip;
  } ctl_t;

  typedef struct packed {
    logic den_pos;
    logic div_done;
  } st_t;

  function automatic uop_t mk_mul(input logic [4:0] a, input logic [4:0] b,
                                  input logic [2:0] add, input logic neg,
                                  input logic [4:0] dst);
    uop_t u;
    u = '{kind: UOP_MUL, a_sel: a, b_sel: b, add_sel: add, neg: neg, dst: dst,
          den_lam: 1'b0};
    return u;
  endfunction

  function automatic uop_t mk_div(input logic [4:0] num, input logic lam,
                                  input logic [4:0] dst);
    uop_t u;
    u = '{kind: UOP_DIV, a_sel: num, b_sel: REG_NONE, add_sel: ADD_ZERO, neg: 1'b0,
          dst: dst, den_lam: lam};
    return u;
  endfunction

  function automatic uop_t mk_ctl(input logic [2:0] kind);
    uop_t u;
    u = '{kind: kind, a_sel: REG_NONE, b_sel: REG_NONE, add_sel: ADD_ZERO,
          neg: 1'b0, dst: REG_NONE, den_lam: 1'b0};
    return u;
  endfunction

  // update sequence; a product is registered, then summed into the accumulator
  function automatic uop_t step_rom(input logic [STEP_W-1:0] s);
    uop_t u;
    case (s)
      5'd0:  u = mk_mul(REG_PH0, REG_TH0, ADD_Y,    1'b1, REG_NONE);
      5'd1:  u = mk_mul(REG_PH1, REG_TH1, ADD_ACC,  1'b1, REG_EPS);
      5'd2:  u = mk_mul(REG_P0,  REG_PH0, ADD_ZERO, 1'b0, REG_NONE);
      5'd3:  u = mk_mul(REG_P1,  REG_PH1, ADD_ACC,  1'b0, REG_PP0);
      5'd4:  u = mk_mul(REG_P2,  REG_PH0, ADD_ZERO, 1'b0, REG_NONE);
      5'd5:  u = mk_mul(REG_P3,  REG_PH1, ADD_ACC,  1'b0, REG_PP1);
      5'd6:  u = mk_mul(REG_PH0, REG_PP0, ADD_LAM,  1'b0, REG_NONE);
      5'd7:  u = mk_mul(REG_PH1, REG_PP1, ADD_ACC,  1'b0, REG_DEN);
      5'd8:  u = mk_ctl(UOP_NOP);
      5'd9:  u = mk_ctl(UOP_CHECK);
      5'd10: u = mk_div(REG_PP0, 1'b0, REG_K0);
      5'd11: u = mk_div(REG_PP1, 1'b0, REG_K1);
      5'd12: u = mk_mul(REG_K0,  REG_EPS, ADD_TH0,  1'b0, REG_TH0);
      5'd13: u = mk_mul(REG_K1,  REG_EPS, ADD_TH1,  1'b0, REG_TH1);
      5'd14: u = mk_mul(REG_K0,  REG_PH0, ADD_ONE,  1'b1, REG_T0);
      5'd15: u = mk_mul(REG_K0,  REG_PH1, ADD_ZERO, 1'b1, REG_T1);
      5'd16: u = mk_mul(REG_K1,  REG_PH0, ADD_ZERO, 1'b1, REG_T2);
      5'd17: u = mk_mul(REG_K1,  REG_PH1, ADD_ONE,  1'b1, REG_T3);
      5'd18: u = mk_mul(REG_T0,  REG_P0,  ADD_ZERO, 1'b0, REG_NONE);
      5'd19: u = mk_mul(REG_T1,  REG_P2,  ADD_ACC,  1'b0, REG_R0);
      5'd20: u = mk_mul(REG_T0,  REG_P1,  ADD_ZERO, 1'b0, REG_NONE);
      5'd21: u = mk_mul(REG_T1,  REG_P3,  ADD_ACC,  1'b0, REG_R1);
      5'd22: u = mk_mul(REG_T2,  REG_P0,  ADD_ZERO, 1'b0, REG_NONE);
      5'd23: u = mk_mul(REG_T3,  REG_P2,  ADD_ACC,  1'b0, REG_R2);
      5'd24: u = mk_mul(REG_T2,  REG_P1,  ADD_ZERO, 1'b0, REG_NONE);
      5'd25: u = mk_mul(REG_T3,  REG_P3,  ADD_ACC,  1'b0, REG_R3);
      5'd26: u = mk_div(REG_R0, 1'b1, REG_P0);
      5'd27: u = mk_div(REG_R1, 1'b1, REG_P1);
      5'd28: u = mk_div(REG_R2, 1'b1, REG_P2);
      5'd29: u = mk_div(REG_R3, 1'b1, REG_P3);
      default: u = mk_ctl(UOP_END);
    endcase
    return u;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- design/rls2_div.sv -----
module rls2_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [63:0]        dvs,
  output logic               done,
  output logic signed [31:0] quo,
  output logic               sat
);
  import rls2_pkg::*;

  logic [64:0] rem;
  logic [63:0] dvd;
  logic [63:0] div_r;
  logic [6:0]  cnt;
  logic        busy;
  logic        neg;
  logic        fin;
  logic [63:0] mag;
  logic [64:0] trial;
  logic signed [63:0] q_signed;

  // rounds to nearest, ties away from zero: |num| + dvs/2 divided by dvs
  assign mag   = (num < 0) ? (64'd0 - 64'(num)) : 64'(num);
  assign trial = {rem[63:0], dvd[63]} - {1'b0, div_r};
  assign q_signed = neg ? (64'sd0 - $signed(dvd)) : $signed(dvd);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        dvd   <= mag + (dvs >> 1);
        div_r <= dvs;
        neg   <= num < 0;
      end else if (busy) begin
        if (trial[64]) begin
          rem <= {rem[63:0], dvd[63]};
          dvd <= {dvd[62:0], 1'b0};
        end else begin
          rem <= trial;
          dvd <= {dvd[62:0], 1'b1};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  assign done = fin;
  assign quo  = sat32(q_signed);
  assign sat  = ovf32(q_signed);

endmodule

// ----- design/rls2_dp.sv -----
module rls2_dp #(
  parameter int FRAC_BITS = rls2_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  input  rls2_pkg::in_t  in_data,
  input  rls2_pkg::ctl_t ctl,
  output rls2_pkg::st_t  stat,
  output rls2_pkg::out_t out_data
);
  import rls2_pkg::*;

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;

  logic [16:0] ff;
  logic [30:0] icov;
  logic signed [31:0] cv0, cv1, cv2, cv3, th0, th1, ph0, ph1, y, eps;
  logic signed [31:0] pp0, pp1, k0, k1, t0, t1, t2, t3, r0, r1, r2, r3;
  logic signed [63:0] den, acc, prod;
  logic        s2_valid;
  logic [2:0]  s2_add;
  logic        s2_neg;
  logic [4:0]  s2_dst;
  logic        sat_hit;

  logic [63:0] lam_raw;
  logic signed [63:0] lam;
  logic signed [31:0] opa, opb;
  logic signed [63:0] fm, base, sum, div_num;
  logic [63:0] div_den;
  logic        div_done, div_sat;
  logic signed [31:0] div_q;
  logic [4:0]  div_dst;
  logic        wr_en, wr_sat;
  logic [4:0]  wr_dst;
  logic signed [31:0] wr_val;

  function automatic logic signed [31:0] pick(
      input logic [4:0] sel,
      input logic signed [31:0] c0, c1, c2, c3, h0, h1, a0, a1, e,
      input logic signed [31:0] q0, q1, g0, g1, u0, u1, u2, u3, v0, v1, v2, v3);
    logic signed [31:0] r;
    case (sel)
      REG_P0:  r = c0;
      REG_P1:  r = c1;
      REG_P2:  r = c2;
      REG_P3:  r = c3;
      REG_TH0: r = h0;
      REG_TH1: r = h1;
      REG_PH0: r = a0;
      REG_PH1: r = a1;
      REG_EPS: r = e;
      REG_PP0: r = q0;
      REG_PP1: r = q1;
      REG_K0:  r = g0;
      REG_K1:  r = g1;
      REG_T0:  r = u0;
      REG_T1:  r = u1;
      REG_T2:  r = u2;
      REG_T3:  r = u3;
      REG_R0:  r = v0;
      REG_R1:  r = v1;
      REG_R2:  r = v2;
      REG_R3:  r = v3;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign lam_raw = ({47'd0, ff} << FRAC_BITS) >> 16;
  assign lam     = (lam_raw == 64'd0) ? 64'sd1 : $signed(lam_raw);

  assign opa = pick(ctl.a_sel, cv0, cv1, cv2, cv3, th0, th1, ph0, ph1, eps,
                    pp0, pp1, k0, k1, t0, t1, t2, t3, r0, r1, r2, r3);
  assign opb = pick(ctl.b_sel, cv0, cv1, cv2, cv3, th0, th1, ph0, ph1, eps,
                    pp0, pp1, k0, k1, t0, t1, t2, t3, r0, r1, r2, r3);

  assign fm = (prod + HALF) >>> FRAC_BITS;

  always_comb begin
    case (s2_add)
      ADD_ACC:  base = acc;
      ADD_Y:    base = 64'(y);
      ADD_LAM:  base = lam;
      ADD_ONE:  base = ONE;
      ADD_TH0:  base = 64'(th0);
      ADD_TH1:  base = 64'(th1);
      default:  base = '0;
    endcase
    sum = s2_neg ? (base - fm) : (base + fm);
  end

  assign div_num = 64'(opa) <<< FRAC_BITS;
  assign div_den = ctl.den_lam ? 64'(lam) : 64'(den);

  rls2_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num   (div_num),
    .dvs   (div_den),
    .done  (div_done),
    .quo   (div_q),
    .sat   (div_sat)
  );

  always_comb begin
    if (div_done) begin
      wr_en  = 1'b1;
      wr_dst = div_dst;
      wr_val = div_q;
      wr_sat = div_sat;
    end else begin
      wr_en  = s2_valid && (s2_dst != REG_NONE) && (s2_dst != REG_DEN);
      wr_dst = s2_dst;
      wr_val = sat32(sum);
      wr_sat = ovf32(sum);
    end
  end

  assign stat.den_pos  = den > 0;
  assign stat.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      ff       <= FF_RESET;
      icov     <= ICOV_RESET;
      cv0      <= 32'(ICOV_RESET);
      cv1      <= '0;
      cv2      <= '0;
      cv3      <= 32'(ICOV_RESET);
      th0      <= '0;
      th1      <= '0;
      s2_valid <= 1'b0;
      sat_hit  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FORGET: ff   <= cfg_data[16:0];
          CFG_ICOV:   icov <= cfg_data[30:0];
          default: ;
        endcase
      end

      s2_valid <= ctl.issue;
      if (ctl.issue) begin
        prod   <= opa * opb;
        s2_add <= ctl.add_sel;
        s2_neg <= ctl.neg;
        s2_dst <= ctl.dst;
      end
      if (s2_valid) begin
        acc <= sum;
        if (s2_dst == REG_DEN) den <= sum;
      end
      if (ctl.div_start) div_dst <= ctl.dst;

      if (wr_en) begin
        if (wr_sat) sat_hit <= 1'b1;
        case (wr_dst)
          REG_P0:  cv0 <= wr_val;
          REG_P1:  cv1 <= wr_val;
          REG_P2:  cv2 <= wr_val;
          REG_P3:  cv3 <= wr_val;
          REG_TH0: th0 <= wr_val;
          REG_TH1: th1 <= wr_val;
          REG_EPS: eps <= wr_val;
          REG_PP0: pp0 <= wr_val;
          REG_PP1: pp1 <= wr_val;
          REG_K0:  k0  <= wr_val;
          REG_K1:  k1  <= wr_val;
          REG_T0:  t0  <= wr_val;
          REG_T1:  t1  <= wr_val;
          REG_T2:  t2  <= wr_val;
          REG_T3:  t3  <= wr_val;
          REG_R0:  r0  <= wr_val;
          REG_R1:  r1  <= wr_val;
          REG_R2:  r2  <= wr_val;
          REG_R3:  r3  <= wr_val;
          default: ;
        endcase
      end

      if (ctl.capture) begin
        ph0     <= in_data.regressor_a;
        ph1     <= in_data.regressor_b;
        y       <= in_data.measured_output;
        sat_hit <= 1'b0;
      end

      if (ctl.reinit) begin
        cv0 <= 32'(icov);
        cv1 <= '0;
        cv2 <= '0;
        cv3 <= 32'(icov);
        th0 <= '0;
        th1 <= '0;
        out_data <= '{estimate_a: '0, estimate_b: '0, prediction_error: '0,
                      status: ST_OK};
      end else if (ctl.finish) begin
        out_data.estimate_a       <= th0;
        out_data.estimate_b       <= th1;
        out_data.prediction_error <= eps;
        out_data.status <= ctl.skip ? ST_SKIP : (sat_hit ? ST_SAT : ST_OK);
      end
    end
  end

endmodule

// ----- design/rls2_ctrl.sv -----
module rls2_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_cmd,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  rls2_pkg::st_t  stat,
  output rls2_pkg::ctl_t ctl
);
  import rls2_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  uop_t              uop;
  logic              accept;

  assign uop      = step_rom(step);
  assign in_stall = state != S_IDLE;
  assign out_valid = state == S_OUT;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    step_next  = step;
    ctl = '{capture: 1'b0, reinit: 1'b0, issue: 1'b0, a_sel: uop.a_sel,
            b_sel: uop.b_sel, add_sel: uop.add_sel, neg: uop.neg, dst: uop.dst,
            div_start: 1'b0, den_lam: uop.den_lam, finish: 1'b0, skip: 1'b0};
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_REINIT) begin
            ctl.reinit = 1'b1;
            state_next = S_OUT;
          end else begin
            ctl.capture = 1'b1;
            step_next   = '0;
            state_next  = S_RUN;
          end
        end
      end
      S_RUN: begin
        case (uop.kind)
          UOP_MUL: begin
            ctl.issue = 1'b1;
            step_next = step + 1'b1;
          end
          UOP_DIV: begin
            ctl.div_start = 1'b1;
            state_next    = S_DIV;
          end
          UOP_CHECK: begin
            if (!stat.den_pos) begin
              ctl.finish = 1'b1;
              ctl.skip   = 1'b1;
              state_next = S_OUT;
            end else begin
              step_next = step + 1'b1;
            end
          end
          UOP_END: begin
            ctl.finish = 1'b1;
            state_next = S_OUT;
          end
          default: step_next = step + 1'b1;
        endcase
      end
      S_DIV: begin
        if (stat.div_done) begin
          step_next  = step + 1'b1;
          state_next = S_RUN;
        end
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ----- design/rls_two_parameter_estimator_top.sv -----
// Two-parameter recursive least squares estimator with forgetting factor.
// Input channel (in_valid / in_stall / in_data): one beat per item; cmd
// selects an update with regressor and measurement, or a reinitialise.
// Output channel (out_valid / out_stall / out_data): one beat per item with
// both estimates, the prediction error and a status code.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// the forgetting factor, index 1 the initial covariance; cfg_ready is always
// high, other indexes are dropped. Write only while no item is in flight.
// One item is in the block at a time; in_stall is high from acceptance until
// the result beat is taken.
// A reinitialise yields its result in the cycle after acceptance. An update runs a
// 30-step sequence on one shared 32x32 multiplier plus six divisions on a
// radix-2 divider; it ends early and skips when the gain denominator is not
// positive. The next item is taken the cycle after the result beat.
// out_data is held stable while out_stall is high.
// Reset brings the registers to their defaults, the covariance to its
// default diagonal and the estimates to zero.
module rls_two_parameter_estimator_top #(
  parameter int FRAC_BITS = rls2_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rls2_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rls2_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);
  import rls2_pkg::*;

  ctl_t ctl;
  st_t  stat;

  assign cfg_ready = 1'b1;

  rls2_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  rls2_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_data  (out_data)
  );

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("not busy after accept");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status != 2'd3)) else $error("bad status code");

endmodule

// ----- test/rls_two_parameter_estimator_top_tb.sv -----
`timescale 1ns / 1ps
module rls_two_parameter_estimator_top_tb;
  import rls2_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  rls_two_parameter_estimator_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // estimator state mirrored in the testbench
  logic [16:0] lam_reg;
  logic [30:0] icov_reg;
  longint cov[4];
  longint theta[2];
  bit sat_seen;

  out_t pending_results[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_skip = 0;
  int n_sat = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      sat_seen = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat_seen = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic longint div_round(longint num, longint den);
    longint m;
    longint q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic void reinit_state();
    cov[0] = icov_reg; cov[1] = 0; cov[2] = 0; cov[3] = icov_reg;
    theta[0] = 0; theta[1] = 0;
  endfunction

  function automatic out_t estimate_step(in_t it);
    out_t o;
    longint p0, p1, lam, eps, pp0, pp1, den, k0, k1;
    longint t[4];
    longint r[4];
    logic [1:0] st;
    st = ST_OK;
    sat_seen = 1'b0;
    if (it.cmd == CMD_REINIT) begin
      reinit_state();
      return '0;
    end
    p0 = longint'(it.regressor_a);
    p1 = longint'(it.regressor_b);
    lam = (longint'(lam_reg) <<< FB) >>> 16;
    if (lam < 1) lam = 1;
    eps = clip32(longint'(it.measured_output) - (qmul(p0, theta[0]) + qmul(p1, theta[1])));
    pp0 = clip32(qmul(cov[0], p0) + qmul(cov[1], p1));
    pp1 = clip32(qmul(cov[2], p0) + qmul(cov[3], p1));
    den = lam + qmul(p0, pp0) + qmul(p1, pp1);
    if (den <= 0) begin
      st = ST_SKIP;
    end else begin
      k0 = clip32(div_round(pp0 <<< FB, den));
      k1 = clip32(div_round(pp1 <<< FB, den));
      theta[0] = clip32(theta[0] + qmul(k0, eps));
      theta[1] = clip32(theta[1] + qmul(k1, eps));
      t[0] = clip32((64'sd1 <<< FB) - qmul(k0, p0));
      t[1] = clip32(-qmul(k0, p1));
      t[2] = clip32(-qmul(k1, p0));
      t[3] = clip32((64'sd1 <<< FB) - qmul(k1, p1));
      r[0] = clip32(qmul(t[0], cov[0]) + qmul(t[1], cov[2]));
      r[1] = clip32(qmul(t[0], cov[1]) + qmul(t[1], cov[3]));
      r[2] = clip32(qmul(t[2], cov[0]) + qmul(t[3], cov[2]));
      r[3] = clip32(qmul(t[2], cov[1]) + qmul(t[3], cov[3]));
      for (int i = 0; i < 4; i++) cov[i] = clip32(div_round(r[i] <<< FB, lam));
    end
    if (st == ST_OK && sat_seen) st = ST_SAT;
    o.estimate_a = theta[0][31:0];
    o.estimate_b = theta[1][31:0];
    o.prediction_error = eps[31:0];
    o.status = st;
    return o;
  endfunction

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    out_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $time, out_data);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.estimate_a !== exp_r.estimate_a) begin
          errors++;
          $display("%0t: estimate_a exp %h got %h", $time, exp_r.estimate_a,
                   out_data.estimate_a);
        end
        if (out_data.estimate_b !== exp_r.estimate_b) begin
          errors++;
          $display("%0t: estimate_b exp %h got %h", $time, exp_r.estimate_b,
                   out_data.estimate_b);
        end
        if (out_data.prediction_error !== exp_r.prediction_error) begin
          errors++;
          $display("%0t: prediction_error exp %h got %h", $time,
                   exp_r.prediction_error, out_data.prediction_error);
        end
        if (out_data.status !== exp_r.status) begin
          errors++;
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, out_data.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d results still expected", pending_results.size());
      $display("rls_two_parameter_estimator_top_tb: FAIL");
      $finish;
    end
  end

  // valid stays up after the beat so back-to-back items need no gap;
  // idle cycles and drain() drop it
  task automatic send_item(in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(estimate_step(it));
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_FORGET) lam_reg = val[16:0];
    else if (idx == CFG_ICOV) icov_reg = val[30:0];
    @(posedge clk);
  endtask

  function automatic in_t mk_update(int a, int b, int y);
    in_t it;
    it.cmd = CMD_UPDATE;
    it.regressor_a = a;
    it.regressor_b = b;
    it.measured_output = y;
    return it;
  endfunction

  function automatic in_t mk_reinit();
    in_t it;
    it.cmd = CMD_REINIT;
    it.regressor_a = $urandom;
    it.regressor_b = $urandom;
    it.measured_output = $urandom;
    return it;
  endfunction

  // well-formed run: a plant y = 1.5*a - 0.75*b plus noise
  function automatic in_t plant_sample();
    int a, b;
    longint y;
    a = $signed($urandom_range(262144)) - 131072;
    b = $signed($urandom_range(262144)) - 131072;
    y = qmul(a, 98304) - qmul(b, 49152) + ($signed($urandom_range(512)) - 256);
    return mk_update(a, b, int'(y));
  endfunction

  function automatic in_t random_item();
    int sel;
    sel = $urandom_range(99);
    if (sel < 4) return mk_reinit();
    if (sel < 75) return plant_sample();
    if (sel < 90) return mk_update($urandom, $urandom, $urandom);
    return mk_update($signed($urandom_range(65536)) * ($urandom_range(1) ? 1 : -1),
                     $urandom_range(1) ? 32'sh80000000 : 32'sh7fffffff, $urandom);
  endfunction

  task automatic test_directed();
    send_item(mk_update(0, 0, 0));
    send_item(mk_update(65536, 0, 65536));
    send_item(mk_update(0, 65536, -65536));
    send_item(mk_update(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    send_item(mk_update(32'sh80000000, 32'sh80000000, 32'sh80000000));
    send_item(mk_reinit());
    send_item(mk_update(32'sh7fffffff, 32'sh80000000, -1));
    send_item(mk_reinit());
    send_item(mk_update(-1, -1, 32'sh7fffffff));
    send_item(mk_update(65536, 65536, 32'sh80000000));
    send_item(mk_reinit());
    // large regressors of opposite signs saturate the covariance-regressor products
    send_item(mk_update(32'sh00400000, -32'sh00400000, 12345));
    send_item(mk_update(32'shffffffff, 32'h00000000, 32'h55555555));
    send_item(mk_update(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa));
    send_item(mk_reinit());
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_FORGET, 32'd65536);
    write_reg(CFG_ICOV, 32'h7fffffff);
    send_item(mk_reinit());
    for (int i = 0; i < 6; i++) send_item(plant_sample());
    send_item(mk_update(32'sh00010000, 32'sh00010000, 32'sh00020000));
    drain();
    write_reg(CFG_FORGET, 32'd1);
    write_reg(CFG_ICOV, 32'd0);
    send_item(mk_reinit());
    for (int i = 0; i < 4; i++) send_item(plant_sample());
    drain();
    write_reg(2'd3, $urandom);
    write_reg(CFG_FORGET, 32'hfffe0000 | 32'd32768);
    write_reg(CFG_ICOV, 32'h80000000 | 32'd65536);
    send_item(mk_reinit());
    for (int i = 0; i < 4; i++) send_item(plant_sample());
    drain();
  endtask

  task automatic test_random_phase(int idle_p, int stall_p, int count);
    send_idle_pct = idle_p;
    stall_pct = stall_p;
    write_reg(CFG_FORGET, $urandom_range(65536, 60000));
    write_reg(CFG_ICOV, $urandom_range(1 << 28));
    send_item(mk_reinit());
    for (int i = 0; i < count; i++) send_item(random_item());
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (1500) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_item(plant_sample());
    join
    drain();
    // sender waits for every result before going on
    for (int i = 0; i < 5; i++) begin
      send_item(random_item());
      drain();
    end
  endtask

  initial begin
    lam_reg = FF_RESET;
    icov_reg = ICOV_RESET;
    reinit_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random_phase(0, 0, 130);
    test_random_phase(59, 0, 130);
    test_random_phase(0, 59, 130);
    test_random_phase(31, 31, 110);
    test_backpressure();
    write_reg(CFG_FORGET, FF_RESET);
    write_reg(CFG_ICOV, ICOV_RESET);
    test_random_phase(0, 0, 10);
    $display("covered %0d items, %0d results (%0d skipped, %0d saturated) over",
             n_items, n_results, n_skip, n_sat);
    $display("register extremes, idle and stall mixes and a long output hold-off");
    if (errors == 0) begin
      $display("rls_two_parameter_estimator_top_tb: PASS");
    end else begin
      $display("rls_two_parameter_estimator_top_tb: FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (out_data.status == ST_SKIP) n_skip++;
      if (out_data.status == ST_SAT) n_sat++;
    end
  end

endmodule

// ----- filelist.f -----
design/rls2_pkg.sv
design/rls2_div.sv
design/rls2_dp.sv
design/rls2_ctrl.sv
design/rls_two_parameter_estimator_top.sv
test/rls_two_parameter_estimator_top_tb.sv
